@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the LCS block.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition must never be seen.
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");

`endif

@@ rtl/lcs_dp_pkg.sv @@
// Package for the LCS dynamic programming block: default sizes, op codes,
// direction codes and sequencer states. No dependencies.
package lcs_dp_pkg;

   localparam int MAX_LEN_DEF = 32;
   localparam int TL_W        = 6;

   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE  = 2'd2;

   typedef enum logic [1:0] {
      DIR_DIAG = 2'd0,
      DIR_UP   = 2'd1,
      DIR_LEFT = 2'd2
   } dir_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_CELL,
      ST_TSTART,
      ST_TREAD,
      ST_TSTEP,
      ST_EREAD,
      ST_EOUT,
      ST_EMPTY
   } state_type;

endpackage

@@ rtl/lcs_dynamic_programming.sv @@
// Longest common subsequence block: string stores, score row, direction table,
// traceback and result emission. Uses lcs_dp_pkg and assert_macros.svh.
// Appends are taken while idle. Compute fills the table one cell per cycle (ST_ROW sets
// up each row), does each traceback step (at most m+n-1) in ST_TREAD and ST_TSTEP, then
// ST_EREAD and ST_EOUT per item plus output stall; one item at a time, input not ready
// until the last result item leaves. Synchronous reset clears lengths, flag, sequencer.
module lcs_dynamic_programming
   import lcs_dp_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_char_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_char_out,
   output logic             rsp_last,
   output logic             rsp_empty_res,
   output logic [TL_W-1:0]  rsp_total_length,
   output logic             rsp_overflowed
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DD = MAX_LEN * MAX_LEN;
   localparam int DW = (DD > 1) ? $clog2(DD) : 1;
   localparam int SW = LW;

   // Storage
   logic [7:0]    first_mem  [MAX_LEN];
   logic [7:0]    second_mem [MAX_LEN];
   logic [SW-1:0] row_mem    [MAX_LEN];
   dir_type       dir_mem    [DD];
   logic [7:0]    rev_mem    [MAX_LEN];

   // Control registers
   state_type     state_ff, state_in;
   logic [LW-1:0] len_a_ff, len_a_in;
   logic [LW-1:0] len_b_ff, len_b_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] jc_ff, jc_in;
   logic [DW-1:0] row_base_ff, row_base_in;
   logic [DW-1:0] c_addr_ff, c_addr_in;
   logic          p_v_ff, p_v_in;
   logic          p_j0_ff, p_j0_in;
   logic          p_top_ff, p_top_in;
   logic [IW-1:0] p_j_ff, p_j_in;
   logic [DW-1:0] p_addr_ff, p_addr_in;
   logic [LW-1:0] ti_ff, ti_in;
   logic [LW-1:0] tj_ff, tj_in;
   logic [DW-1:0] t_addr_ff, t_addr_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] e_idx_ff, e_idx_in;

   // Payload registers
   logic [SW-1:0] diag_ff, left_ff;
   logic [7:0]    a_rd_ff, b_rd_ff, rev_rd_ff;
   logic [SW-1:0] up_rd_ff;
   dir_type       dir_rd_ff;

   // Memory controls
   logic          a_we, b_we, a_re, cell_re, dir_re, rev_we, rev_re;
   logic [IW-1:0] a_raddr;
   logic [LW-1:0] ti_m1;
   logic [LW-1:0] ti_nx, tj_nx;
   logic          fill_busy;

   // Shared compare/add unit for one cell
   logic [SW-1:0] up_val, diag_eff, left_eff, score_new;
   dir_type       dir_new;
   logic [6:0]    cnt_wide;

   assign ti_m1   = ti_ff - LW'(1);
   assign a_raddr = (state_ff == ST_ROW) ? i_ff[IW-1:0] : ti_m1[IW-1:0];

   // Score one cell from the registered reads
   always_comb begin
      up_val   = p_top_ff ? '0 : up_rd_ff;
      diag_eff = p_j0_ff ? '0 : diag_ff;
      left_eff = p_j0_ff ? '0 : left_ff;
      if (a_rd_ff == b_rd_ff) begin
         score_new = diag_eff + SW'(1);
         dir_new   = DIR_DIAG;
      end else if (up_val >= left_eff) begin
         score_new = up_val;
         dir_new   = DIR_UP;
      end else begin
         score_new = left_eff;
         dir_new   = DIR_LEFT;
      end
   end

   // Sequencer: next state and controls
   always_comb begin
      state_in    = state_ff;
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      jc_in       = jc_ff;
      row_base_in = row_base_ff;
      c_addr_in   = c_addr_ff;
      p_v_in      = 1'b0;
      p_j0_in     = p_j0_ff;
      p_top_in    = p_top_ff;
      p_j_in      = p_j_ff;
      p_addr_in   = p_addr_ff;
      ti_in       = ti_ff;
      tj_in       = tj_ff;
      t_addr_in   = t_addr_ff;
      cnt_in      = cnt_ff;
      e_idx_in    = e_idx_ff;
      a_we        = 1'b0;
      b_we        = 1'b0;
      a_re        = 1'b0;
      cell_re     = 1'b0;
      dir_re      = 1'b0;
      rev_we      = 1'b0;
      rev_re      = 1'b0;
      ti_nx       = ti_ff;
      tj_nx       = tj_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_APPEND_A: begin
                     if (len_a_ff == LW'(MAX_LEN)) begin
                        ovf_in = 1'b1;
                     end else begin
                        a_we     = 1'b1;
                        len_a_in = len_a_ff + LW'(1);
                     end
                  end
                  OP_APPEND_B: begin
                     if (len_b_ff == LW'(MAX_LEN)) begin
                        ovf_in = 1'b1;
                     end else begin
                        b_we     = 1'b1;
                        len_b_in = len_b_ff + LW'(1);
                     end
                  end
                  OP_COMPUTE: begin
                     cnt_in      = '0;
                     i_in        = '0;
                     row_base_in = '0;
                     if (len_a_ff == '0 || len_b_ff == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        state_in = ST_ROW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Fetch the row character and rewind the column
         ST_ROW: begin
            a_re      = 1'b1;
            jc_in     = '0;
            c_addr_in = row_base_ff;
            state_in  = ST_CELL;
         end
         // Issue one cell per cycle into the scoring stage
         ST_CELL: begin
            cell_re   = 1'b1;
            p_v_in    = 1'b1;
            p_j0_in   = (jc_ff == '0);
            p_top_in  = (i_ff == '0);
            p_j_in    = jc_ff[IW-1:0];
            p_addr_in = c_addr_ff;
            jc_in     = jc_ff + LW'(1);
            c_addr_in = c_addr_ff + DW'(1);
            if (jc_ff == len_b_ff - LW'(1)) begin
               row_base_in = row_base_ff + DW'(MAX_LEN);
               i_in        = i_ff + LW'(1);
               if (i_ff + LW'(1) == len_a_ff) begin
                  state_in = ST_TSTART;
               end else begin
                  state_in = ST_ROW;
               end
            end
         end
         // Last cell lands this cycle; start at the bottom right corner
         ST_TSTART: begin
            ti_in     = len_a_ff;
            tj_in     = len_b_ff;
            t_addr_in = p_addr_ff;
            state_in  = ST_TREAD;
         end
         ST_TREAD: begin
            a_re     = 1'b1;
            dir_re   = 1'b1;
            state_in = ST_TSTEP;
         end
         // Walk one step back through the direction table
         ST_TSTEP: begin
            case (dir_rd_ff)
               DIR_DIAG: begin
                  rev_we    = 1'b1;
                  cnt_in    = cnt_ff + LW'(1);
                  ti_nx     = ti_ff - LW'(1);
                  tj_nx     = tj_ff - LW'(1);
                  t_addr_in = DW'(t_addr_ff - DW'(MAX_LEN + 1));
               end
               DIR_UP: begin
                  ti_nx     = ti_ff - LW'(1);
                  t_addr_in = t_addr_ff - DW'(MAX_LEN);
               end
               default: begin
                  tj_nx     = tj_ff - LW'(1);
                  t_addr_in = t_addr_ff - DW'(1);
               end
            endcase
            ti_in = ti_nx;
            tj_in = tj_nx;
            if (ti_nx == '0 || tj_nx == '0) begin
               if (cnt_in == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  e_idx_in = IW'(cnt_in - LW'(1));
                  state_in = ST_EREAD;
               end
            end else begin
               state_in = ST_TREAD;
            end
         end
         ST_EREAD: begin
            rev_re   = 1'b1;
            state_in = ST_EOUT;
         end
         // Hold the item until taken, then fetch the next one
         ST_EOUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (e_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  e_idx_in = e_idx_ff - IW'(1);
                  state_in = ST_EREAD;
               end
            end
         end
         ST_EMPTY: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
         p_v_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         ovf_ff   <= ovf_in;
         p_v_ff   <= p_v_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Counters and addresses
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      jc_ff       <= jc_in;
      row_base_ff <= row_base_in;
      c_addr_ff   <= c_addr_in;
      p_j0_ff     <= p_j0_in;
      p_top_ff    <= p_top_in;
      p_j_ff      <= p_j_in;
      p_addr_ff   <= p_addr_in;
      ti_ff       <= ti_in;
      tj_ff       <= tj_in;
      t_addr_ff   <= t_addr_in;
      e_idx_ff    <= e_idx_in;
   end

   // String stores
   always_ff @(posedge clock) begin
      if (a_we) begin
         first_mem[len_a_ff[IW-1:0]] <= req_char_in;
      end
      if (a_re) begin
         a_rd_ff <= first_mem[a_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         second_mem[len_b_ff[IW-1:0]] <= req_char_in;
      end
      if (cell_re) begin
         b_rd_ff <= second_mem[jc_ff[IW-1:0]];
      end
   end

   // Score row: read ahead, write back from the scoring stage
   always_ff @(posedge clock) begin
      if (p_v_ff) begin
         row_mem[p_j_ff] <= score_new;
         diag_ff         <= up_val;
         left_ff         <= score_new;
      end
      if (cell_re) begin
         up_rd_ff <= row_mem[jc_ff[IW-1:0]];
      end
   end

   // Direction table
   always_ff @(posedge clock) begin
      if (p_v_ff) begin
         dir_mem[p_addr_ff] <= dir_new;
      end
      if (dir_re) begin
         dir_rd_ff <= dir_mem[t_addr_ff];
      end
   end

   // Reversed result buffer
   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[cnt_ff[IW-1:0]] <= a_rd_ff;
      end
      if (rev_re) begin
         rev_rd_ff <= rev_mem[e_idx_ff];
      end
   end

   // Result fields
   assign cnt_wide         = 7'(cnt_ff);
   assign rsp_char_out     = (state_ff == ST_EMPTY) ? 8'd0 : rev_rd_ff;
   assign rsp_last         = (state_ff == ST_EMPTY) ||
                             ((state_ff == ST_EOUT) && (e_idx_ff == '0));
   assign rsp_empty_res    = (state_ff == ST_EMPTY);
   assign rsp_total_length = (cnt_wide > 7'd63) ? TL_W'(63) : cnt_wide[TL_W-1:0];
   assign rsp_overflowed   = ovf_ff;

   // States in which the scoring stage may still be busy
   assign fill_busy = (state_ff == ST_CELL) || (state_ff == ST_ROW) ||
                      (state_ff == ST_TSTART);

`include "assert_macros.svh"

   `ASSERT_NEVER(a_ready_with_rsp, req_ready && rsp_valid)
   `ASSERT_IMPLIES(a_empty_is_last, rsp_valid && rsp_empty_res, rsp_last && rsp_total_length == '0)
   `ASSERT_IMPLIES(a_score_in_fill, p_v_ff, fill_busy)
   `ASSERT_NEVER(a_count_bound, cnt_ff > len_a_ff || cnt_ff > len_b_ff)

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for lcs_dynamic_programming: a directed table, then random
// appends and computes, with every result item checked against a typed expectation or
// a local LCS predictor. Depends on lcs_dp_pkg and the RTL of the block.
module testbench
   import lcs_dp_pkg::*;
();

   localparam int MAX_LEN        = MAX_LEN_DEF;
   localparam int RANDOM_ITEMS   = 238;
   localparam int QUIET_ITEMS    = 40;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // one result item as the block emits it
   typedef struct packed {
      logic [7:0]      char_out;
      logic            last;
      logic            empty_res;
      logic [TL_W-1:0] total_length;
      logic            overflowed;
   } lcs_item_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic [1:0]   op;
      logic [7:0]   ch;
      logic         typed;
      lcs_item_type want;
   } stim_row_type;

   localparam lcs_item_type EMPTY_CLEAN = '{8'h00, 1'b1, 1'b1, 6'd0, 1'b0};
   localparam lcs_item_type NONE        = '0;
   localparam int DIRECTED_ROWS = 22;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [1:0]      req_op = OP_APPEND_A;
   logic [7:0]      req_char_in = 8'h00;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [7:0]      rsp_char_out;
   logic            rsp_last;
   logic            rsp_empty_res;
   logic [TL_W-1:0] rsp_total_length;
   logic            rsp_overflowed;

   // predictor state
   logic [7:0]  seq_a [MAX_LEN];
   logic [7:0]  seq_b [MAX_LEN];
   int unsigned len_a = 0;
   int unsigned len_b = 0;
   logic        overflow_seen = 1'b0;
   int unsigned score_tab [MAX_LEN+1][MAX_LEN+1];
   dir_type     dir_tab [MAX_LEN+1][MAX_LEN+1];

   lcs_item_type subseq_q [$];
   logic [7:0]   mirror_q [$];
   lcs_item_type oldest;
   int unsigned  errors = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  ready_hold = 0;
   bit           quiet = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_COMPUTE,  8'h00, 1'b1, EMPTY_CLEAN},                   // both strings empty
      '{OP_UNUSED,   8'hFF, 1'b0, NONE},
      '{OP_APPEND_A, 8'h00, 1'b0, NONE},
      '{OP_APPEND_B, 8'hFF, 1'b0, NONE},
      '{OP_COMPUTE,  8'hFF, 1'b1, EMPTY_CLEAN},                   // nothing matches
      '{OP_APPEND_A, 8'hFF, 1'b0, NONE},
      '{OP_COMPUTE,  8'h5A, 1'b1, '{8'hFF, 1'b1, 1'b0, 6'd1, 1'b0}},
      '{OP_APPEND_B, 8'h00, 1'b0, NONE},
      '{OP_COMPUTE,  8'h00, 1'b0, NONE},                          // tie between up and left
      '{OP_APPEND_A, 8'h55, 1'b0, NONE},
      '{OP_APPEND_B, 8'hAA, 1'b0, NONE},
      '{OP_APPEND_A, 8'hAA, 1'b0, NONE},
      '{OP_APPEND_B, 8'h55, 1'b0, NONE},
      '{OP_COMPUTE,  8'hA5, 1'b0, NONE},
      '{OP_UNUSED,   8'h00, 1'b0, NONE},
      '{OP_APPEND_A, 8'h41, 1'b0, NONE},
      '{OP_APPEND_B, 8'h41, 1'b0, NONE},
      '{OP_APPEND_A, 8'h42, 1'b0, NONE},
      '{OP_APPEND_B, 8'h43, 1'b0, NONE},
      '{OP_APPEND_A, 8'h43, 1'b0, NONE},
      '{OP_APPEND_B, 8'h42, 1'b0, NONE},
      '{OP_COMPUTE,  8'h00, 1'b0, NONE}
   };

   lcs_dynamic_programming #(.MAX_LEN(MAX_LEN)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_total_length (rsp_total_length),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // fill the score and direction tables, walk back from the last cell and
   // queue the common subsequence in forward order
   task automatic predict_subsequence();
      logic [7:0]   rev [MAX_LEN];
      int unsigned  count;
      int unsigned  i;
      int unsigned  j;
      int unsigned  tl;
      lcs_item_type item;
      count = 0;
      for (i = 0; i <= len_a; i++) score_tab[i][0] = 0;
      for (j = 0; j <= len_b; j++) score_tab[0][j] = 0;
      for (i = 1; i <= len_a; i++) begin
         for (j = 1; j <= len_b; j++) begin
            if (seq_a[i-1] == seq_b[j-1]) begin
               score_tab[i][j] = score_tab[i-1][j-1] + 1;
               dir_tab[i][j]   = DIR_DIAG;
            end else if (score_tab[i-1][j] >= score_tab[i][j-1]) begin
               score_tab[i][j] = score_tab[i-1][j];
               dir_tab[i][j]   = DIR_UP;
            end else begin
               score_tab[i][j] = score_tab[i][j-1];
               dir_tab[i][j]   = DIR_LEFT;
            end
         end
      end
      i = len_a;
      j = len_b;
      while (i > 0 && j > 0) begin
         case (dir_tab[i][j])
            DIR_DIAG: begin
               if (count < MAX_LEN) begin
                  rev[count] = seq_a[i-1];
                  count++;
               end
               i--;
               j--;
            end
            DIR_UP:  i--;
            default: j--;
         endcase
      end
      tl = (count > 63) ? 63 : count;
      if (count == 0) begin
         item = '{8'h00, 1'b1, 1'b1, '0, overflow_seen};
         subseq_q.push_back(item);
      end else begin
         for (int k = 0; k < count; k++) begin
            item.char_out     = rev[count-1-k];
            item.last         = (k + 1 == count);
            item.empty_res    = 1'b0;
            item.total_length = tl[TL_W-1:0];
            item.overflowed   = overflow_seen;
            subseq_q.push_back(item);
         end
      end
   endtask

   // present one item, hold it until accepted, then advance the predictor
   task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                            input logic typed, input lcs_item_type want);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_char_in <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         OP_APPEND_A: begin
            if (len_a >= MAX_LEN) overflow_seen = 1'b1;
            else begin
               seq_a[len_a] = ch;
               len_a++;
            end
         end
         OP_APPEND_B: begin
            if (len_b >= MAX_LEN) overflow_seen = 1'b1;
            else begin
               seq_b[len_b] = ch;
               len_b++;
            end
         end
         OP_COMPUTE: begin
            if (typed) subseq_q.push_back(want);
            else predict_subsequence();
         end
         default: ;
      endcase
   endtask

   // mostly a small alphabet so strings share characters, sometimes any byte
   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 99) < 85) return 8'h41 + 8'($urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic check_field(input string field_name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, exp_v, act_v);
         errors++;
      end
   endtask

   // stimulus: directed table, then random appends and computes
   initial begin
      int unsigned sent;
      int unsigned r;
      logic [1:0]  op;
      logic [7:0]  ch;
      sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_item(directed_rows[row].op, directed_rows[row].ch,
                   directed_rows[row].typed, directed_rows[row].want);
      end
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            op = OP_APPEND_A;
            ch = pick_char();
            mirror_q.push_back(ch);
         end else if (r < 80) begin
            op = OP_APPEND_B;
            // copy the first string most of the time so long matches build up
            if (mirror_q.size() != 0 && $urandom_range(0, 3) != 0) ch = mirror_q.pop_front();
            else ch = pick_char();
         end else if (r < 95) begin
            op = OP_COMPUTE;
            ch = 8'($urandom_range(0, 255));
         end else begin
            op = OP_UNUSED;
            ch = 8'($urandom_range(0, 255));
         end
         send_item(op, ch, 1'b0, NONE);
         sent++;
      end
      req_valid <= 1'b0;
      while (subseq_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // result side: stall in random bursts, steady ready in the quiet tail
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            ready_hold = $urandom_range(0, 16);
         end else begin
            rsp_ready <= 1'b1;
            ready_hold = $urandom_range(1, 40);
         end
      end else begin
         ready_hold--;
      end
   end

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (subseq_q.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual char_out %h last %b",
                     $time, rsp_char_out, rsp_last);
            errors++;
         end else begin
            oldest = subseq_q.pop_front();
            check_field("char_out", oldest.char_out, rsp_char_out);
            check_field("last", 8'(oldest.last), 8'(rsp_last));
            check_field("empty_res", 8'(oldest.empty_res), 8'(rsp_empty_res));
            check_field("total_length", 8'(oldest.total_length), 8'(rsp_total_length));
            check_field("overflowed", 8'(oldest.overflowed), 8'(rsp_overflowed));
         end
      end
   end

   // drop the run if no item moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

endmodule

@@ lcs_dynamic_programming.f @@
+incdir+rtl
rtl/lcs_dp_pkg.sv
rtl/lcs_dynamic_programming.sv
sim/testbench.sv
